// File: design/dept_pkg.sv
// Package for the debug entry parent tracker.
// Holds sizes, tag codes, transaction and stack entry types, and the scope flag rule.
// No dependencies.
package dept_pkg;

  localparam int unsigned MAX_DEPTH = 64;
  localparam longint unsigned MAX_DIES = 64'd1048576;

  localparam int unsigned DEPTH_W = 6;
  localparam int unsigned TAG_W = 16;
  localparam int unsigned NUM_W = 20;
  localparam int unsigned LVL_W = $clog2(MAX_DEPTH + 1);
  localparam int unsigned IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_DIES + 1);

  localparam logic [TAG_W-1:0] TAG_LEXICAL_BLOCK = 16'h000b;
  localparam logic [TAG_W-1:0] TAG_INLINED_SUB = 16'h001d;
  localparam logic [TAG_W-1:0] TAG_SUBPROGRAM = 16'h002e;
  localparam logic [TAG_W-1:0] TAG_VARIABLE = 16'h0034;

  localparam logic [NUM_W-1:0] NUM_LAST = NUM_W'(MAX_DIES - 1);

  typedef struct packed {
    logic               new_unit;
    logic [DEPTH_W-1:0] entry_depth;
    logic [TAG_W-1:0]   tag_code;
  } entry_t;

  typedef struct packed {
    logic [NUM_W-1:0] entry_number;
    logic [NUM_W-1:0] parent_number;
    logic             has_parent;
    logic             in_function;
    logic             count_overflow;
  } result_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [NUM_W-1:0]   number;
    logic               in_func;
  } stack_entry_t;

  localparam int unsigned SE_W = $bits(stack_entry_t);

  // Scope flag of a new entry from its tag and its parent's flag.
  function automatic logic scope_flag(input logic [TAG_W-1:0] tag, input logic parent_inside);
    logic flag;
    if (tag inside {TAG_LEXICAL_BLOCK, TAG_VARIABLE}) begin
      flag = parent_inside;
    end else if (tag inside {TAG_SUBPROGRAM, TAG_INLINED_SUB}) begin
      flag = 1'b1;
    end else begin
      flag = 1'b0;
    end
    return flag;
  endfunction

endpackage

// File: design/debug_entry_parent_tracker.sv
// Top level of the debug entry parent tracker: sequencer plus output register.
// Depends on dept_pkg and dept_ctrl.
//
//   channel   direction  handshake                  payload
//   entry     in         entry_valid / entry_stall   entry_t  (new_unit, depth, tag)
//   result    out        result_valid / result_stall result_t (numbers and flags)
//
// Each entry is taken, then its depth is compared with the top of stack; each ancestor it
// pops costs a stack RAM read and another compare; a parent read and a finish step follow.
// The single read port of the stack RAM and the shared depth compare keep the pops sequential.
// Reset clears the level and the counter at once; the stack RAM needs no clearing pass.
// The output register frees the sequencer: a held result stalls only the finish cycle
// of the following entry.
module debug_entry_parent_tracker
  import dept_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    entry_valid,
  output logic    entry_stall,
  input  entry_t  entry,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic    busy;
  logic    res_valid;
  logic    res_take;
  result_t res;

  dept_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .entry_valid(entry_valid),
    .busy       (busy),
    .entry      (entry),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  assign entry_stall = busy;
  assign res_take = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_take) begin
      result_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      result <= res;
    end
  end

  // Busy right after a transaction is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    entry_valid && !entry_stall |=> entry_stall)
    else $error("entry accepted while sequencer stayed idle");

  // A finished result only comes from a busy sequencer.
  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> busy)
    else $error("result offered while sequencer idle");

  // Saturated counter always gives the last number.
  a_overflow_number: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.count_overflow |-> result.entry_number == NUM_LAST)
    else $error("overflow result with unexpected entry number");

  // Root entries carry no parent number.
  a_root_parent: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.has_parent |-> result.parent_number == '0)
    else $error("parent number set on root entry");

endmodule

// File: design/dept_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module dept_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/dept_ctrl.sv
// Sequencer of the parent tracker: entry numbering, depth compare and stack walk.
// Depends on dept_pkg and dept_ram (ancestor stack storage).
module dept_ctrl
  import dept_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    entry_valid,
  output logic    busy,
  input  entry_t  entry,
  output logic    res_valid,
  input  logic    res_take,
  output result_t res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_LOAD,
    S_PAR,
    S_DONE
  } state_t;

  state_t             state;
  logic [LVL_W-1:0]   lvl;
  logic [CNT_W-1:0]   cnt;
  stack_entry_t       top;
  logic [DEPTH_W-1:0] cur_depth;
  logic [TAG_W-1:0]   cur_tag;
  logic [NUM_W-1:0]   number;
  logic               ovf;
  logic               first;

  logic [CNT_W-1:0]   cnt_base;
  logic               depth_eq;
  logic               depth_ge;
  logic               has_par;
  logic               new_flag;
  stack_entry_t       rd_entry;
  logic [SE_W-1:0]    rdata;
  logic               ram_we;
  logic [IDX_W-1:0]   waddr;
  logic [IDX_W-1:0]   raddr;

  // Shared compare of the incoming depth against the cached top of stack.
  assign depth_eq = (top.depth == cur_depth);
  assign depth_ge = (top.depth >= cur_depth);

  assign cnt_base = entry.new_unit ? '0 : cnt;

  // Level L lives at index L-1; the parent of the top and the next top both sit at lvl-2.
  assign raddr = IDX_W'(lvl - LVL_W'(2));
  assign waddr = IDX_W'(lvl - LVL_W'(1));

  assign rd_entry = stack_entry_t'(rdata);
  assign has_par = (lvl >= LVL_W'(2));
  assign new_flag = scope_flag(cur_tag, has_par & rd_entry.in_func);

  assign busy = (state != S_IDLE);
  assign res_valid = (state == S_DONE);
  assign ram_we = (state == S_DONE) && res_take;

  always_comb begin
    res.entry_number = number;
    res.parent_number = has_par ? rd_entry.number : '0;
    res.has_parent = has_par;
    res.in_function = new_flag;
    res.count_overflow = ovf;
  end

  dept_ram #(
    .WIDTH(SE_W),
    .DEPTH(MAX_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata({top.depth, top.number, new_flag}),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lvl <= '0;
      cnt <= '0;
      first <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (entry_valid) begin
            cur_depth <= entry.entry_depth;
            cur_tag <= entry.tag_code;
            if (entry.new_unit) begin
              lvl <= '0;
            end
            if (cnt_base < CNT_W'(MAX_DIES)) begin
              number <= NUM_W'(cnt_base);
              cnt <= cnt_base + CNT_W'(1);
              ovf <= 1'b0;
            end else begin
              number <= NUM_LAST;
              cnt <= cnt_base;
              ovf <= 1'b1;
            end
            first <= 1'b1;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          first <= 1'b0;
          if (lvl != '0 && first && depth_eq) begin
            // same depth: the top takes the new number
            top.number <= number;
            state <= S_PAR;
          end else if (lvl != '0 && depth_ge) begin
            // pop; the new top arrives from the stack next cycle
            lvl <= lvl - LVL_W'(1);
            state <= S_LOAD;
          end else begin
            // push, overwriting the top when full
            if (lvl < LVL_W'(MAX_DEPTH)) begin
              lvl <= lvl + LVL_W'(1);
            end
            top.depth <= cur_depth;
            top.number <= number;
            state <= S_PAR;
          end
        end
        S_LOAD: begin
          top <= rd_entry;
          state <= S_CMP;
        end
        S_PAR: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            top.in_func <= new_flag;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
